// ===== rtl/mpfp_pkg.sv =====
// Mouse packet FIFO port: shared request/response types and codes.
// No dependencies; used by the interfaces, the byte FIFO and the top level.
package mpfp_pkg;

    // Command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_MOUSE = 2'd2;

    // Register offsets
    localparam logic [7:0] OFS_DATA   = 8'd0;
    localparam logic [7:0] OFS_STATUS = 8'd4;

    // Packet header: bit 3 always set, buttons in bits 2..0
    localparam logic [4:0] PKT_HDR_HI = 5'b00001;

    typedef struct packed {
        logic [1:0]        command;
        logic [7:0]        bus_offset;
        logic [7:0]        write_byte;
        logic [3:0]        write_mask;
        logic [2:0]        buttons;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       bad_offset;
    } t_rsp;

    // Control from the decoder to the byte FIFO
    typedef struct packed {
        logic [1:0] push_cnt;  // bytes offered this cycle, 0..3
        logic       pop;       // pop the head byte if one is waiting
    } t_fifo_ctl;

endpackage

// ===== rtl/mpfp_req_if.sv =====
// Request channel of the mouse packet FIFO port: valid/ready plus t_req.
// Depends on mpfp_pkg.
interface mpfp_req_if import mpfp_pkg::*; ();
    logic valid;
    logic ready;
    t_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// ===== rtl/mpfp_rsp_if.sv =====
// Response channel of the mouse packet FIFO port: valid/ready plus t_rsp.
// Depends on mpfp_pkg.
interface mpfp_rsp_if import mpfp_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp rsp;

    modport source (output valid, output rsp, input ready);
    modport sink   (input valid, input rsp, output ready);
endinterface

// ===== rtl/mpfp_byte_fifo.sv =====
// Ring byte FIFO with one slot kept free; takes up to three bytes per cycle.
// Depends on mpfp_pkg (t_fifo_ctl).
module mpfp_byte_fifo import mpfp_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_fifo_ctl       i_ctl,
    input  logic [2:0][7:0] i_bytes,
    output logic [7:0]      o_head,
    output logic            o_waiting
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = PW + 1;

    logic [PW-1:0] r_wp, r_rp;
    logic [PW-1:0] n_wp, n_rp;
    logic [7:0]    r_slots [DEPTH];

    logic [CW-1:0] w_count, w_free;
    logic [1:0]    w_store;

    // Pointer plus a small step, wrapped at DEPTH
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                               input logic [1:0] k);
        logic [CW-1:0] s;
        s = {1'b0, p} + CW'(k);
        if (s >= CW'(DEPTH))
            s = s - CW'(DEPTH);
        return s[PW-1:0];
    endfunction

    // Occupancy and room left
    always_comb begin
        if (r_wp >= r_rp)
            w_count = {1'b0, r_wp} - {1'b0, r_rp};
        else
            w_count = {1'b0, r_wp} + CW'(DEPTH) - {1'b0, r_rp};
        w_free = CW'(DEPTH - 1) - w_count;
        // bytes that meet a full FIFO are dropped
        if (w_free >= CW'(i_ctl.push_cnt))
            w_store = i_ctl.push_cnt;
        else
            w_store = w_free[1:0];
    end

    assign o_waiting = (r_wp != r_rp);
    assign o_head    = r_slots[r_rp];

    always_comb begin
        n_wp = wrap_add(r_wp, w_store);
        n_rp = (i_ctl.pop && o_waiting) ? wrap_add(r_rp, 2'd1) : r_rp;
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // Slot storage, no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < w_store)
                r_slots[wrap_add(r_wp, 2'(i))] <= i_bytes[i];
        end
    end

endmodule

// ===== rtl/mouse_packet_fifo_port_core.sv =====
// Mouse packet FIFO port, top level.
// An accepted request goes into the input register, then its result into the result
// register. Throughput: one request per cycle while o_rsp is ready; the FIFO
// is read and updated in the single stage between the two registers.
// Reset clears the pointers and the valid flags; slot contents stay undefined.
module mouse_packet_fifo_port_core import mpfp_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpfp_req_if.sink   i_req,
    mpfp_rsp_if.source o_rsp
);

    logic      r_in_vld;
    t_req      r_in;
    logic      r_out_vld;
    t_rsp      r_out;

    logic      w_adv;
    t_fifo_ctl w_ctl;
    logic [2:0][7:0] w_bytes;
    logic [7:0] w_head;
    logic       w_waiting;
    t_rsp       n_out;

    // Stage advances when the result register is free or being drained
    assign w_adv       = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready)
            r_in <= i_req.req;
    end

    // Command decode
    always_comb begin
        w_ctl    = '0;
        n_out    = '0;
        w_bytes  = '0;
        unique case (r_in.command)
            CMD_READ: begin
                if (r_in.bus_offset == OFS_DATA) begin
                    w_ctl.pop       = w_adv;
                    n_out.read_data = w_waiting ? w_head : 8'd0;
                end else if (r_in.bus_offset == OFS_STATUS) begin
                    n_out.read_data = {7'd0, w_waiting};
                end else begin
                    n_out.bad_offset = 1'b1;
                end
            end
            CMD_WRITE: begin
                w_bytes[0] = r_in.write_byte;
                if (w_adv && r_in.bus_offset == OFS_DATA && r_in.write_mask[0])
                    w_ctl.push_cnt = 2'd1;
            end
            CMD_MOUSE: begin
                w_bytes[0] = {PKT_HDR_HI, r_in.buttons};
                w_bytes[1] = r_in.move_x;
                w_bytes[2] = 8'(-r_in.move_y);
                if (w_adv)
                    w_ctl.push_cnt = 2'd3;
            end
            default: begin
                // unused command: no effect, zero response
            end
        endcase
    end

    mpfp_byte_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_bytes   (w_bytes),
        .o_head    (w_head),
        .o_waiting (w_waiting)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv)
            r_out <= n_out;
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.rsp   = r_out;

endmodule

// ===== tb/sv/mpfp_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the mouse packet FIFO port: watches both channels,
// predicts every response from accepted requests and compares them in order.
// Depends on mpfp_pkg and the mpfp_req_if / mpfp_rsp_if interfaces.
module mpfp_checker import mpfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mpfp_req_if  i_req_mon,
    mpfp_rsp_if  i_rsp_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_dropped
);

    localparam int SLOT_COUNT    = 4;
    localparam int REPORT_LIMIT  = 10;

    // Shadow copy of the byte ring; one slot always stays free
    logic [7:0] slot_mem [SLOT_COUNT];
    logic [1:0] wr_slot;
    logic [1:0] rd_slot;

    t_rsp expected_rsp_q [$];
    int   fail_cnt    = 0;
    int   checked_cnt = 0;
    int   drop_cnt    = 0;

    function automatic logic [1:0] next_slot(input logic [1:0] p);
        return (p == 2'(SLOT_COUNT - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    // Store a byte unless the ring is full
    function automatic void push_port_byte(input logic [7:0] b);
        if (next_slot(wr_slot) != rd_slot) begin
            slot_mem[wr_slot] = b;
            wr_slot = next_slot(wr_slot);
        end else begin
            drop_cnt++;
        end
    endfunction

    // Apply one request to the shadow ring and return its response
    function automatic t_rsp predict_port_access(input t_req r);
        t_rsp res;
        logic waiting;
        res = '0;
        waiting = (rd_slot != wr_slot);
        case (r.command)
            CMD_READ: begin
                if (r.bus_offset == OFS_DATA) begin
                    if (waiting) begin
                        res.read_data = slot_mem[rd_slot];
                        rd_slot = next_slot(rd_slot);
                    end
                end else if (r.bus_offset == OFS_STATUS) begin
                    res.read_data = {7'd0, waiting};
                end else begin
                    res.bad_offset = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (r.bus_offset == OFS_DATA && r.write_mask[0])
                    push_port_byte(r.write_byte);
            end
            CMD_MOUSE: begin
                // header, dx, then negated dy, each mod 256
                push_port_byte({PKT_HDR_HI, r.buttons});
                push_port_byte(r.move_x);
                push_port_byte(8'h00 - r.move_y);
            end
            default: ;
        endcase
        return res;
    endfunction

    // Compare the response first: it always belongs to an earlier request
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            wr_slot = '0;
            rd_slot = '0;
            expected_rsp_q.delete();
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got = i_rsp_mon.rsp;
                if (expected_rsp_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT)
                        $display("%0t: response with no request waiting: data %02h bad %0b",
                                 $realtime, got.read_data, got.bad_offset);
                end else begin
                    want = expected_rsp_q.pop_front();
                    checked_cnt++;
                    if (got.read_data !== want.read_data ||
                        got.bad_offset !== want.bad_offset) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_LIMIT)
                            $display("%0t: mismatch: data %02h bad %0b, expected %02h bad %0b",
                                     $realtime, got.read_data, got.bad_offset,
                                     want.read_data, want.bad_offset);
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready)
                expected_rsp_q.push_back(predict_port_access(i_req_mon.req));
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_rsp_q.size();
        o_checked    <= checked_cnt;
        o_dropped    <= drop_cnt;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for mouse_packet_fifo_port_core: clock, reset, request
// stimulus and response back-pressure; checking is done by mpfp_checker.
// Depends on mpfp_pkg, the channel interfaces, the core and mpfp_checker.
module tb;
    import mpfp_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_ITEMS   = 240;
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_ITEMS    = 60;

    logic i_clk;
    logic i_rst_n;

    mpfp_req_if req_if ();
    mpfp_rsp_if rsp_if ();

    int fail_count;
    int pending;
    int checked;
    int dropped;

    int send_idle_pct;
    int stall_pct;
    logic hold_rsp;
    int cycle_cnt = 0;
    int sent_cnt  = 0;
    int mouse_cnt = 0;

    int idle_tab  [4] = '{0, 61, 0, 26};
    int stall_tab [4] = '{0, 0, 61, 26};

    mouse_packet_fifo_port_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    mpfp_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_if),
        .i_rsp_mon    (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_dropped    (dropped)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt, pending);
            $display("mouse_packet_fifo_port_core regression: fail");
            $finish;
        end
    end

    // Response back-pressure
    always @(posedge i_clk) begin
        rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
    end

    function automatic t_req make_req(input logic [1:0] cmd, input logic [7:0] ofs,
                                      input logic [7:0] wbyte, input logic [3:0] mask,
                                      input logic [2:0] btn, input logic signed [7:0] mx,
                                      input logic signed [7:0] my);
        t_req r;
        r.command    = cmd;
        r.bus_offset = ofs;
        r.write_byte = wbyte;
        r.write_mask = mask;
        r.buttons    = btn;
        r.move_x     = mx;
        r.move_y     = my;
        return r;
    endfunction

    // Mostly pops and pushes that keep the small ring cycling, some noise
    function automatic t_req random_port_req();
        t_req r;
        int pick;
        r.command    = CMD_READ;
        r.bus_offset = 8'($urandom_range(255));
        r.write_byte = 8'($urandom_range(255));
        r.write_mask = 4'($urandom_range(15));
        r.buttons    = 3'($urandom_range(7));
        r.move_x     = 8'($urandom_range(255));
        r.move_y     = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 36) begin
            r.bus_offset = OFS_DATA;
        end else if (pick < 46) begin
            r.bus_offset = OFS_STATUS;
        end else if (pick < 52) begin
            // random offset, mostly a bad one
        end else if (pick < 70) begin
            r.command = CMD_WRITE;
            if ($urandom_range(9) != 0)
                r.bus_offset = OFS_DATA;
        end else if (pick < 95) begin
            r.command = CMD_MOUSE;
        end else begin
            r.command = CMD_UNUSED;
        end
        return r;
    endfunction

    // Offer one request, with a random gap in front, until it is taken
    task automatic send_req(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req   <= r;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        sent_cnt++;
        if (r.command == CMD_MOUSE)
            mouse_cnt++;
    endtask

    initial begin
        req_if.valid  = 1'b0;
        req_if.req    = '0;
        hold_rsp      = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty reads, bad offsets, ignored writes, full ring
        send_req(make_req(CMD_READ,   OFS_DATA,   8'h00, 4'h0, 3'd0, 8'sh00, 8'sh00));
        send_req(make_req(CMD_READ,   OFS_STATUS, 8'h00, 4'h0, 3'd0, 8'sh00, 8'sh00));
        send_req(make_req(CMD_READ,   8'd1,       8'h00, 4'h0, 3'd0, 8'sh00, 8'sh00));
        send_req(make_req(CMD_READ,   8'd255,     8'hFF, 4'hF, 3'd7, 8'sh7F, 8'sh80));
        send_req(make_req(CMD_WRITE,  OFS_DATA,   8'h3C, 4'hE, 3'd0, 8'sh00, 8'sh00));
        send_req(make_req(CMD_WRITE,  OFS_STATUS, 8'hC3, 4'hF, 3'd0, 8'sh00, 8'sh00));
        send_req(make_req(CMD_UNUSED, 8'd255,     8'hFF, 4'hF, 3'd7, 8'sh7F, 8'sh7F));
        send_req(make_req(CMD_READ,   OFS_STATUS, 8'h00, 4'h0, 3'd0, 8'sh00, 8'sh00));
        send_req(make_req(CMD_WRITE,  OFS_DATA,   8'hFF, 4'h1, 3'd0, 8'sh00, 8'sh00));
        send_req(make_req(CMD_WRITE,  OFS_DATA,   8'h00, 4'hF, 3'd0, 8'sh00, 8'sh00));
        send_req(make_req(CMD_WRITE,  OFS_DATA,   8'hA5, 4'h1, 3'd0, 8'sh00, 8'sh00));
        // ring full: this byte and the whole packet are dropped
        send_req(make_req(CMD_WRITE,  OFS_DATA,   8'h5A, 4'h1, 3'd0, 8'sh00, 8'sh00));
        send_req(make_req(CMD_MOUSE,  OFS_DATA,   8'h00, 4'h0, 3'd3, 8'sh11, 8'sh22));
        send_req(make_req(CMD_READ,   OFS_STATUS, 8'h00, 4'h0, 3'd0, 8'sh00, 8'sh00));
        repeat (4)
            send_req(make_req(CMD_READ, OFS_DATA, 8'h00, 4'h0, 3'd0, 8'sh00, 8'sh00));
        // most negative motion: dy negates to itself
        send_req(make_req(CMD_MOUSE,  OFS_DATA,   8'h00, 4'h0, 3'd7, 8'sh80, 8'sh80));
        repeat (3)
            send_req(make_req(CMD_READ, OFS_DATA, 8'h00, 4'h0, 3'd0, 8'sh00, 8'sh00));
        // one byte waiting: the packet keeps only its first two bytes
        send_req(make_req(CMD_WRITE,  OFS_DATA,   8'h11, 4'h1, 3'd0, 8'sh00, 8'sh00));
        send_req(make_req(CMD_MOUSE,  OFS_DATA,   8'h00, 4'h0, 3'd0, 8'sh7F, 8'sh7F));
        repeat (3)
            send_req(make_req(CMD_READ, OFS_DATA, 8'h00, 4'h0, 3'd0, 8'sh00, 8'sh00));
        // button-only event
        send_req(make_req(CMD_MOUSE,  OFS_DATA,   8'h00, 4'h0, 3'd5, 8'sh00, 8'sh00));

        // Random traffic under each idling mix
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph];
            stall_pct    <= stall_tab[ph];
            repeat (PHASE_ITEMS)
                send_req(random_port_req());
        end

        // Long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        stall_pct    <= 0;
        fork
            begin
                hold_rsp <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rsp <= 1'b0;
            end
            repeat (HOLD_ITEMS)
                send_req(random_port_req());
        join

        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d mouse events) under four idling mixes and a hold-off",
                 sent_cnt, mouse_cnt);
        $display("%0d responses compared, %0d bytes dropped on a full ring, %0d failures",
                 checked, dropped, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("mouse_packet_fifo_port_core regression: pass");
        end else begin
            $display("mouse_packet_fifo_port_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mpfp_pkg.sv
rtl/mpfp_req_if.sv
rtl/mpfp_rsp_if.sv
rtl/mpfp_byte_fifo.sv
rtl/mouse_packet_fifo_port_core.sv
tb/sv/mpfp_checker.sv
tb/sv/tb.sv
